// ===== sv/odr_pkg.sv =====
`timescale 1ns / 1ps

package odr_pkg;

    // one input word: a 32-bit rgba pixel, 8 bits per channel
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pixel_in_t;

    // one output word: rgb555 plus alpha flag, and the end-of-block mark
    typedef struct packed {
        logic [15:0] packed_pixel;
        logic        block_last;
    } pixel_out_t;

    typedef logic signed [3:0] dither_t;

    localparam logic [7:0] ALPHA_MATCH = 8'h40;
    localparam logic [7:0] CHANNEL_MAX = 8'hFF;

    // 4x4 ordered-dither matrix, indexed by row and column mod 4
    function automatic dither_t dither_cell(input logic [1:0] row, input logic [1:0] col);
        dither_t offset;
        offset = 4'sd0;
        case ({row, col})
            4'h0: offset = -4'sd4;
            4'h1: offset =  4'sd0;
            4'h2: offset = -4'sd3;
            4'h3: offset =  4'sd1;
            4'h4: offset =  4'sd2;
            4'h5: offset = -4'sd2;
            4'h6: offset =  4'sd3;
            4'h7: offset = -4'sd1;
            4'h8: offset = -4'sd3;
            4'h9: offset =  4'sd1;
            4'hA: offset = -4'sd4;
            4'hB: offset =  4'sd0;
            4'hC: offset =  4'sd3;
            4'hD: offset = -4'sd1;
            4'hE: offset =  4'sd2;
            4'hF: offset = -4'sd2;
            default: offset = 4'sd0;
        endcase
        return offset;
    endfunction

    // add the dither offset, clamp to 0..255, keep the top 5 bits
    function automatic logic [4:0] to_five(input logic [7:0] channel, input dither_t offset);
        logic signed [9:0] sum;
        logic [7:0]        clamped;
        sum = $signed({2'b00, channel}) + 10'(offset);
        if (sum < 10'sd0)
        begin
            clamped = 8'h00;
        end
        else if (sum > $signed({2'b00, CHANNEL_MAX}))
        begin
            clamped = CHANNEL_MAX;
        end
        else
        begin
            clamped = sum[7:0];
        end
        return clamped[7:3];
    endfunction

endpackage

// ===== sv/ordered_dither_rgb32_to_rgb16.sv =====
`timescale 1ns / 1ps
// an input register (stage a) and an output register (stage b) form a
// two-stage pipeline, each stage moving whenever the next one is free;
// throughput: one word per cycle while out_stall stays low
// reset: rst_n (async, active low) empties both stages, zeroes the row and
// column position and clears dither_enable
module ordered_dither_rgb32_to_rgb16 #(
    parameter int BLOCK_SIDE = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: dither enable in bit 0
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data,
    // pixel input
    input  logic                   in_valid,
    output logic                   in_stall,
    input  odr_pkg::pixel_in_t     in_word,
    // packed pixel output
    output logic                   out_valid,
    input  logic                   out_stall,
    output odr_pkg::pixel_out_t    out_word
);

    localparam int POS_W = $clog2(BLOCK_SIDE);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_SIDE - 1);

    // configuration register; the user must write it only while the block is idle, the block does not enforce this
    logic dither_enable_reg;

    // position of the next pixel inside the macroblock
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] row_next;
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] col_next;

    // stage a: captured pixel, its dither offset and end-of-block mark
    logic                 a_valid_reg;
    odr_pkg::pixel_in_t   a_pixel_reg;
    odr_pkg::dither_t     a_offset_reg;
    logic                 a_last_reg;

    // stage b: finished output word
    logic                 b_valid_reg;
    odr_pkg::pixel_out_t  b_word_reg;
    odr_pkg::pixel_out_t  b_word_next;

    logic in_accept;
    logic b_take;
    logic a_take;

    odr_pkg::dither_t cur_offset;
    logic             cur_last;

    assign cfg_ready = 1'b1;

    // stage b frees up when empty or when its word leaves this cycle
    assign b_take    = !b_valid_reg || !out_stall;
    // stage a can load when empty or when it moves into stage b
    assign a_take    = !a_valid_reg || b_take;
    assign in_stall  = !a_take;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = b_valid_reg;
    assign out_word  = b_word_reg;

    // offset and last mark come from the position at accept time
    always_comb
    begin
        cur_offset = dither_enable_reg ? odr_pkg::dither_cell(row_reg[1:0], col_reg[1:0])
                                       : 4'sd0;
        cur_last   = (row_reg == POS_LAST) && (col_reg == POS_LAST);
    end

    // raster walk through the block, column first
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg + 1'b1;
        if (col_reg == POS_LAST)
        begin
            col_next = '0;
            row_next = (row_reg == POS_LAST) ? '0 : row_reg + 1'b1;
        end
    end

    // dither, clamp, truncate and pack
    always_comb
    begin
        b_word_next.packed_pixel[4:0]   = odr_pkg::to_five(a_pixel_reg.red_in, a_offset_reg);
        b_word_next.packed_pixel[9:5]   = odr_pkg::to_five(a_pixel_reg.green_in, a_offset_reg);
        b_word_next.packed_pixel[14:10] = odr_pkg::to_five(a_pixel_reg.blue_in, a_offset_reg);
        b_word_next.packed_pixel[15]    = (a_pixel_reg.alpha_in == odr_pkg::ALPHA_MATCH);
        b_word_next.block_last          = a_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dither_enable_reg <= 1'b0;
            row_reg           <= '0;
            col_reg           <= '0;
            a_valid_reg       <= 1'b0;
            b_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                dither_enable_reg <= cfg_data;
            end
            if (in_accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (a_take)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_take)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_pixel_reg  <= in_word;
            a_offset_reg <= cur_offset;
            a_last_reg   <= cur_last;
        end
        if (b_take && a_valid_reg)
        begin
            b_word_reg <= b_word_next;
        end
    end

endmodule

// ===== sv/odr_checker.sv =====
`timescale 1ns / 1ps

module odr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input odr_pkg::pixel_out_t out_word
);

    // a stalled output word stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // a stalled output word holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_word))
        else $error("output word changed while stalled");

    // an empty output stage never holds back the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output stage");

    // a new output word always follows an accepted input word that passed through stage a
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("output word without matching input word");

endmodule

bind ordered_dither_rgb32_to_rgb16 odr_checker u_odr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int BLOCK_SIDE = 16;
    // receiver hold-off long enough to back the pipeline up into the input
    localparam int LONG_HOLD  = 64;
    localparam int TARGET_PIXELS = 1800;

    // ------------------------------------------------------------------
    // predictor and store of expected output words
    // ------------------------------------------------------------------
    class rgb555_predictor;
        odr_pkg::pixel_out_t expected_words[$];
        bit         dither_on;
        int         row;
        int         col;
        int         errors;
        // 4x4 ordered-dither offsets, row-major, row and column mod 4
        int         offset_lut[16] = '{-4, 0, -3, 1,
                                        2, -2, 3, -1,
                                       -3, 1, -4, 0,
                                        3, -1, 2, -2};

        function new();
            dither_on = 1'b0;
            row       = 0;
            col       = 0;
            errors    = 0;
        endfunction

        function void set_dither(bit on);
            dither_on = on;
        endfunction

        function logic [4:0] quantize_channel(logic [7:0] channel, int offset);
            int level;
            level = int'(channel) + offset;
            if (level < 0)
            begin
                level = 0;
            end
            if (level > 255)
            begin
                level = 255;
            end
            return level[7:3];
        endfunction

        function void note_pixel(odr_pkg::pixel_in_t pix);
            odr_pkg::pixel_out_t exp_word;
            int         offset;
            logic [4:0] r5;
            logic [4:0] g5;
            logic [4:0] b5;
            offset = dither_on ? offset_lut[(row % 4) * 4 + (col % 4)] : 0;
            r5 = quantize_channel(pix.red_in, offset);
            g5 = quantize_channel(pix.green_in, offset);
            b5 = quantize_channel(pix.blue_in, offset);
            exp_word.packed_pixel = {(pix.alpha_in == odr_pkg::ALPHA_MATCH), b5, g5, r5};
            exp_word.block_last   = (row == BLOCK_SIDE - 1) && (col == BLOCK_SIDE - 1);
            expected_words.push_back(exp_word);
            col++;
            if (col == BLOCK_SIDE)
            begin
                col = 0;
                row = (row == BLOCK_SIDE - 1) ? 0 : row + 1;
            end
        endfunction

        function void check_word(odr_pkg::pixel_out_t got);
            odr_pkg::pixel_out_t exp_word;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected output word %h", $time, got);
                errors++;
                return;
            end
            exp_word = expected_words.pop_front();
            if (got.packed_pixel !== exp_word.packed_pixel)
            begin
                $display("%0t: packed_pixel expected %h actual %h", $time,
                         exp_word.packed_pixel, got.packed_pixel);
                errors++;
            end
            if (got.block_last !== exp_word.block_last)
            begin
                $display("%0t: block_last expected %b actual %b", $time,
                         exp_word.block_last, got.block_last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       in_valid;
    logic       in_stall;
    odr_pkg::pixel_in_t  in_word;
    logic       out_valid;
    logic       out_stall;
    odr_pkg::pixel_out_t out_word;

    rgb555_predictor predictor = new();

    // set by the stimulus to ask the receiver for one long hold-off
    bit hold_request = 1'b0;
    // set by the receiver once that hold-off has started
    bit hold_served = 1'b0;
    // phases where the sender never idles
    bit steady_sender = 1'b0;
    int pixels_sent = 0;

    ordered_dither_rgb32_to_rgb16 #(
        .BLOCK_SIDE(BLOCK_SIDE)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // hard stop in case the pipeline hangs
    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // channel value biased toward both clamp edges
    function automatic logic [7:0] random_channel();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            return 8'($urandom_range(0, 7));
        end
        else if (r < 4)
        begin
            return 8'($urandom_range(248, 255));
        end
        return 8'($urandom);
    endfunction

    // alpha value biased toward the match value and its neighbors
    function automatic logic [7:0] random_alpha();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            return odr_pkg::ALPHA_MATCH;
        end
        else if (r < 3)
        begin
            return 8'($urandom_range(8'h3F, 8'h41));
        end
        return 8'($urandom);
    endfunction

    function automatic odr_pkg::pixel_in_t random_pixel();
        odr_pkg::pixel_in_t pix;
        pix.red_in   = random_channel();
        pix.green_in = random_channel();
        pix.blue_in  = random_channel();
        pix.alpha_in = random_alpha();
        return pix;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one input word after an optional idle gap, wait for acceptance
    task automatic send_pixel(input odr_pkg::pixel_in_t pix, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_word  <= odr_pkg::pixel_in_t'($urandom);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= pix;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predictor.note_pixel(pix);
        pixels_sent++;
    endtask

    // drop the input, drain the pipeline, then write the enable bit
    task automatic write_dither_enable(input bit on);
        @(negedge clk);
        in_valid <= 1'b0;
        while (predictor.pending() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= on;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        predictor.set_dither(on);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= 1'($urandom);
    endtask

    task automatic send_directed(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input logic [7:0] a);
        odr_pkg::pixel_in_t pix;
        pix.red_in   = r;
        pix.green_in = g;
        pix.blue_in  = b;
        pix.alpha_in = a;
        send_pixel(pix, pick_gap());
    endtask

    // ------------------------------------------------------------------
    // output side: random stall pattern and checking
    // ------------------------------------------------------------------
    initial
    begin
        int s;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request && !hold_served)
            begin
                // long hold-off so the block fills and stalls its input
                hold_served = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                s = pick_gap();
                if (s == 0)
                begin
                    // stall-free stretch, sometimes quite long
                    out_stall <= 1'b0;
                    repeat ($urandom_range(0, 9) == 0 ? 60 : $urandom_range(1, 12))
                        @(negedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat (s) @(negedge clk);
                end
            end
        end
    end

    // every output word taken is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            predictor.check_word(out_word);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int  phase;
        int  phase_len;
        bit  dither_setting;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, plain truncation: all-zero, all-ones, alpha match and neighbors
        write_dither_enable(1'b0);
        send_directed(8'h00, 8'h00, 8'h00, 8'h00);
        send_directed(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_directed(8'h07, 8'h08, 8'hF8, 8'h40);
        send_directed(8'hF7, 8'h0F, 8'h10, 8'h3F);
        send_directed(8'hAA, 8'h55, 8'h80, 8'h41);
        send_directed(8'h55, 8'hAA, 8'h7F, 8'hBF);
        send_directed(8'h01, 8'hFE, 8'h03, 8'h40);
        send_directed(8'hFC, 8'h04, 8'hFB, 8'h00);

        // directed, dither on: clamp at zero and at full scale across
        // all four columns of the matrix and more than one row
        write_dither_enable(1'b1);
        send_directed(8'h00, 8'h01, 8'h02, 8'h40);
        send_directed(8'h03, 8'h00, 8'h01, 8'h3F);
        send_directed(8'hFF, 8'hFE, 8'hFD, 8'h41);
        send_directed(8'hFC, 8'hFF, 8'hFB, 8'h40);
        send_directed(8'h00, 8'hFF, 8'h00, 8'hFF);
        send_directed(8'hFF, 8'h00, 8'hFF, 8'h00);
        send_directed(8'h04, 8'h07, 8'h08, 8'h40);
        send_directed(8'hF8, 8'hF9, 8'hFA, 8'h80);
        send_directed(8'h02, 8'h03, 8'hFE, 8'h40);
        send_directed(8'h01, 8'hFD, 8'hFC, 8'h7F);
        send_directed(8'h05, 8'h06, 8'h09, 8'h40);
        send_directed(8'hFF, 8'hFF, 8'hFF, 8'h40);
        send_directed(8'h00, 8'h00, 8'h00, 8'h01);
        send_directed(8'h80, 8'h7F, 8'h81, 8'hC0);

        // random phases, enable toggled between them; phase lengths are random
        // and seldom multiples of the block, so the enable can change mid-block
        phase          = 0;
        dither_setting = 1'b0;
        while (pixels_sent < TARGET_PIXELS)
        begin
            write_dither_enable(dither_setting);
            phase_len     = $urandom_range(150, 300);
            if (phase_len > TARGET_PIXELS - pixels_sent)
            begin
                phase_len = TARGET_PIXELS - pixels_sent;
            end
            steady_sender = (phase % 3 == 1);
            if (phase == 2)
            begin
                // back-to-back words against a long receiver hold-off
                steady_sender = 1'b1;
                hold_request  = 1'b1;
            end
            repeat (phase_len)
            begin
                send_pixel(random_pixel(), steady_sender ? 0 : pick_gap());
            end
            dither_setting = ~dither_setting;
            phase++;
        end

        // drain, then wait on a little to catch stray output words
        @(negedge clk);
        in_valid <= 1'b0;
        while (predictor.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (predictor.errors == 0 && predictor.pending() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/odr_pkg.sv
sv/ordered_dither_rgb32_to_rgb16.sv
sv/odr_checker.sv
verif/tb.sv
